[rtl/core/bsis_pkg.sv]
// bsis_pkg: shared widths, register codes and types of the bilinear sub-pixel shift unit
`default_nettype none
package bsis_pkg;

    localparam int POS_W         = 9;
    localparam int PIX_W         = 8;
    localparam int DIM_W         = 10;
    localparam int SHIFT_W       = 19;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 19;

    localparam int MAX_DIM_DEF   = 512;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [DIM_W-1:0] DIM_RST  = 10'd512;
    localparam logic [PIX_W-1:0] FILL_RST = 8'd225;
    localparam logic [PIX_W-1:0] PIX_MAX  = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_SHIFT_X      = 3'd2,
        CFG_SHIFT_Y      = 3'd3,
        CFG_FILL_VALUE   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_RENDER = 1'b1
    } t_mode;

    // which bank holds each of the four neighbors
    typedef struct packed {
        logic x0_odd;
        logic x_clamp;
        logic y0_odd;
        logic y_clamp;
    } t_nbr_sel;

endpackage
`default_nettype wire

[rtl/core/bsis_bank.sv]
// bsis_bank: one bank of the reference image, one write and one registered read per cycle
`default_nettype none
module bsis_bank
    import bsis_pkg::*;
#(
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [PIX_W-1:0]  i_wdata,
    output logic      [PIX_W-1:0]  o_rdata
);

    logic [PIX_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_addr];
    end

endmodule
`default_nettype wire

[rtl/core/bsis_blend.sv]
// bsis_blend: neighbor selection, horizontal and vertical blend, rounding and fill
`default_nettype none
module bsis_blend
    import bsis_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic                 i_inside,
    input  wire t_nbr_sel             i_sel,
    input  wire logic [FRAC_BITS-1:0] i_fx,
    input  wire logic [FRAC_BITS-1:0] i_fy,
    input  wire logic [PIX_W-1:0]     i_q [4],
    input  wire logic [PIX_W-1:0]     i_fill,
    output logic                      o_done,
    output logic      [PIX_W-1:0]     o_pixel_out,
    output logic                      o_inside_res
);

    localparam int WGT_W = FRAC_BITS + 1;
    localparam int TOP_W = PIX_W + FRAC_BITS;
    localparam int VAL_W = PIX_W + 2 * FRAC_BITS;
    localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic [VAL_W:0]   RND_HALF = (VAL_W + 1)'(1) << (2 * FRAC_BITS - 1);

    // stage 3: bank data arrives with the side info
    logic                 r3_vld, r3_inside;
    t_nbr_sel             r3_sel;
    logic [FRAC_BITS-1:0] r3_fx, r3_fy;
    // stage 4: row blends
    logic                 r4_vld, r4_inside;
    logic [FRAC_BITS-1:0] r4_fy;
    logic [TOP_W-1:0]     r4_top, r4_bot;
    // stage 5: full blend
    logic                 r5_vld, r5_inside;
    logic [VAL_W-1:0]     r5_val;

    logic [PIX_W-1:0] p00, p10, p01, p11;
    logic [1:0]       b00, b10, b01, b11;
    logic             x1_odd, y1_odd;
    logic [WGT_W-1:0] wx0, wx1, wy0, wy1;
    logic [TOP_W-1:0] n_top, n_bot;
    logic [VAL_W-1:0] n_val;
    logic [VAL_W:0]   rnd;
    logic [VAL_W:0]   rq;
    logic [PIX_W-1:0] sat;

    always_comb begin
        x1_odd = r3_sel.x0_odd ^ ~r3_sel.x_clamp;
        y1_odd = r3_sel.y0_odd ^ ~r3_sel.y_clamp;
        b00    = {r3_sel.y0_odd, r3_sel.x0_odd};
        b10    = {r3_sel.y0_odd, x1_odd};
        b01    = {y1_odd, r3_sel.x0_odd};
        b11    = {y1_odd, x1_odd};
        p00    = i_q[b00];
        p10    = i_q[b10];
        p01    = i_q[b01];
        p11    = i_q[b11];
        wx1    = {1'b0, r3_fx};
        wx0    = WGT_ONE - wx1;
        n_top  = TOP_W'(p00) * TOP_W'(wx0) + TOP_W'(p10) * TOP_W'(wx1);
        n_bot  = TOP_W'(p01) * TOP_W'(wx0) + TOP_W'(p11) * TOP_W'(wx1);
    end

    always_comb begin
        wy1   = {1'b0, r4_fy};
        wy0   = WGT_ONE - wy1;
        n_val = VAL_W'(r4_top) * VAL_W'(wy0) + VAL_W'(r4_bot) * VAL_W'(wy1);
    end

    // round half up, then saturate
    always_comb begin
        rnd = (VAL_W + 1)'(r5_val) + RND_HALF;
        rq  = rnd >> (2 * FRAC_BITS);
        if (rq > (VAL_W + 1)'(PIX_MAX)) begin
            sat = PIX_MAX;
        end else begin
            sat = rq[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld       <= 1'b0;
            r4_vld       <= 1'b0;
            r5_vld       <= 1'b0;
            o_done       <= 1'b0;
            o_inside_res <= 1'b0;
        end else begin
            r3_vld       <= i_vld;
            r4_vld       <= r3_vld;
            r5_vld       <= r4_vld;
            o_done       <= r5_vld;
            o_inside_res <= r5_vld & r5_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_inside <= i_inside;
        r3_sel    <= i_sel;
        r3_fx     <= i_fx;
        r3_fy     <= i_fy;
        r4_inside <= r3_inside;
        r4_fy     <= r3_fy;
        r4_top    <= n_top;
        r4_bot    <= n_bot;
        r5_inside <= r4_inside;
        r5_val    <= n_val;
        o_pixel_out <= r5_inside ? sat : i_fill;
    end

endmodule
`default_nettype wire

[rtl/core/bilinear_subpixel_image_shift_unit.sv]
// bilinear_subpixel_image_shift_unit: top level, config registers, source point, banked image store
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+------------------------------------------
//  command   | in        | start, busy         | i_mode, i_pos_x, i_pos_y, i_pixel_in
//  result    | out       | o_done (one cycle)  | o_pixel_out, o_inside_res
//  config    | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
//  one item per cycle while busy is low; a render item's result is registered at each pipeline stage
//  the image sits in four banks by column and row parity, so the four neighbors are
//  read together; writes and reads hit the banks in the same stage, in item order
//  busy is set in reset and cleared by the first clock with reset released; no clearing pass,
//  the store is unknown until written; reset clears valid bits and sets config registers to defaults
//  the result side cannot stall, so the pipeline always advances
`default_nettype none
module bilinear_subpixel_image_shift_unit
    import bsis_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_mode,
    input  wire logic [POS_W-1:0]      i_pos_x,
    input  wire logic [POS_W-1:0]      i_pos_y,
    input  wire logic [PIX_W-1:0]      i_pixel_in,
    output logic                       o_done,
    output logic      [PIX_W-1:0]      o_pixel_out,
    output logic                       o_inside_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int X_W    = $clog2(MAX_DIM);
    localparam int CI_W   = X_W - 1;
    localparam int ADDR_W = 2 * CI_W;
    localparam int SX_A   = (POS_W > X_W) ? POS_W + FRAC_BITS : X_W + FRAC_BITS;
    localparam int SX_W   = ((SX_A > SHIFT_W) ? SX_A : SHIFT_W) + 2;

    // config registers
    logic                      r_busy;
    logic [DIM_W-1:0]          r_frame_width, r_frame_height;
    logic signed [SHIFT_W-1:0] r_shift_x, r_shift_y;
    logic [PIX_W-1:0]          r_fill_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b1;
            r_frame_width  <= DIM_RST;
            r_frame_height <= DIM_RST;
            r_shift_x      <= '0;
            r_shift_y      <= '0;
            r_fill_value   <= FILL_RST;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                    CFG_SHIFT_X:      r_shift_x      <= i_cfg_data[SHIFT_W-1:0];
                    CFG_SHIFT_Y:      r_shift_y      <= i_cfg_data[SHIFT_W-1:0];
                    CFG_FILL_VALUE:   r_fill_value   <= i_cfg_data[PIX_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy = r_busy;

    // stage 1: source point
    logic                   accept;
    logic signed [SX_W-1:0] n_sx, n_sy;
    logic                   r1_vld;
    t_mode                  r1_mode;
    logic [POS_W-1:0]       r1_px, r1_py;
    logic [PIX_W-1:0]       r1_pix;
    logic signed [SX_W-1:0] r1_sx, r1_sy;

    always_comb begin
        accept = start & ~r_busy;
        n_sx   = $signed(SX_W'({i_pos_x, {FRAC_BITS{1'b0}}})) - SX_W'(r_shift_x);
        n_sy   = $signed(SX_W'({i_pos_y, {FRAC_BITS{1'b0}}})) - SX_W'(r_shift_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mode <= t_mode'(i_mode);
        r1_px   <= i_pos_x;
        r1_py   <= i_pos_y;
        r1_pix  <= i_pixel_in;
        r1_sx   <= n_sx;
        r1_sy   <= n_sy;
    end

    // stage 2: inside test, neighbor coordinates, bank addresses
    logic [DIM_W-1:0]       w_eff, h_eff, wm1, hm1;
    logic signed [SX_W-1:0] lim_x, lim_y;
    logic                   n_inside;
    logic [X_W-1:0]         x0, y0;
    logic [X_W:0]           x0p1, y0p1;
    logic [CI_W-1:0]        col_idx [2];
    logic [CI_W-1:0]        row_idx [2];
    t_nbr_sel               n_sel;
    logic                   wr_ok;
    logic [ADDR_W-1:0]      n_addr [4];
    logic [3:0]             n_we;

    logic                   r2_vld, r2_inside;
    t_nbr_sel               r2_sel;
    logic [FRAC_BITS-1:0]   r2_fx, r2_fy;
    logic [ADDR_W-1:0]      r2_addr [4];
    logic [3:0]             r2_we;
    logic [PIX_W-1:0]       r2_wdata;

    always_comb begin
        w_eff = (int'(r_frame_width) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_frame_width;
        h_eff = (int'(r_frame_height) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_frame_height;
        wm1   = w_eff - 1'b1;
        hm1   = h_eff - 1'b1;
        lim_x = $signed(SX_W'({wm1, {FRAC_BITS{1'b0}}}));
        lim_y = $signed(SX_W'({hm1, {FRAC_BITS{1'b0}}}));
        n_inside = (w_eff != '0) && (h_eff != '0) && !r1_sx[SX_W-1] && !r1_sy[SX_W-1]
                   && (r1_sx <= lim_x) && (r1_sy <= lim_y);

        x0   = r1_sx[FRAC_BITS +: X_W];
        y0   = r1_sy[FRAC_BITS +: X_W];
        x0p1 = {1'b0, x0} + 1'b1;
        y0p1 = {1'b0, y0} + 1'b1;
        // even bank holds whichever of x0, x0+1 is even; odd bank the other
        col_idx[0] = x0p1[X_W-1:1];
        col_idx[1] = x0[X_W-1:1];
        row_idx[0] = y0p1[X_W-1:1];
        row_idx[1] = y0[X_W-1:1];

        n_sel.x0_odd  = x0[0];
        n_sel.x_clamp = (int'(x0) == int'(wm1));
        n_sel.y0_odd  = y0[0];
        n_sel.y_clamp = (int'(y0) == int'(hm1));

        wr_ok = r1_vld && (r1_mode == MODE_WRITE)
                && (int'(r1_px) < MAX_DIM) && (int'(r1_py) < MAX_DIM);
        for (int k = 0; k < 4; k++) begin
            if (r1_mode == MODE_WRITE) begin
                n_addr[k] = {CI_W'(r1_py >> 1), CI_W'(r1_px >> 1)};
            end else begin
                n_addr[k] = {row_idx[k / 2], col_idx[k % 2]};
            end
            n_we[k] = wr_ok && (2'(k) == {r1_py[0], r1_px[0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r2_we  <= '0;
        end else begin
            r2_vld <= r1_vld && (r1_mode == MODE_RENDER);
            r2_we  <= n_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_inside <= n_inside;
        r2_sel    <= n_sel;
        r2_fx     <= r1_sx[FRAC_BITS-1:0];
        r2_fy     <= r1_sy[FRAC_BITS-1:0];
        r2_wdata  <= r1_pix;
        for (int k = 0; k < 4; k++) begin
            r2_addr[k] <= n_addr[k];
        end
    end

    // banks indexed {row parity, column parity}
    logic [PIX_W-1:0] bank_q [4];

    for (genvar g = 0; g < 4; g++) begin : g_bank
        bsis_bank #(
            .ADDR_W (ADDR_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (r2_we[g]),
            .i_addr  (r2_addr[g]),
            .i_wdata (r2_wdata),
            .o_rdata (bank_q[g])
        );
    end

    bsis_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r2_vld),
        .i_inside     (r2_inside),
        .i_sel        (r2_sel),
        .i_fx         (r2_fx),
        .i_fy         (r2_fy),
        .i_q          (bank_q),
        .i_fill       (r_fill_value),
        .o_done       (o_done),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res)
    );

    // a result comes only from a render item taken at the unit's input
    a_done_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && i_mode, 6))
        else $error("result strobe without a render item");

    a_one_bank_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r2_we))
        else $error("more than one bank written");

    a_write_no_read : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_we != '0) |-> !r2_vld)
        else $error("bank write and render in the same stage");

    a_inside_strobe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_inside_res |-> o_done)
        else $error("inside flag without result strobe");

    a_busy_after_reset : assert property (@(posedge i_clk)
        $past(i_rst_n) && i_rst_n |=> !busy)
        else $error("busy after reset released");

endmodule
`default_nettype wire

[tb/bilinear_subpixel_image_shift_unit_checker.sv]
// result checker for the sub-pixel shift unit: mirrors the image store, predicts and compares
`timescale 1ns / 100ps
module bilinear_subpixel_image_shift_unit_checker
    import bsis_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic                  i_mode,
    input  wire logic [POS_W-1:0]      i_pos_x,
    input  wire logic [POS_W-1:0]      i_pos_y,
    input  wire logic [PIX_W-1:0]      i_pixel_in,
    input  wire logic                  i_done,
    input  wire logic [PIX_W-1:0]      i_pixel_out,
    input  wire logic                  i_inside_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending
);

    localparam longint FIX_ONE = longint'(1) << FRAC_BITS_DEF;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             in_frame;
    } t_shift_pix;

    logic [PIX_W-1:0] image_mem [0:MAX_DIM_DEF*MAX_DIM_DEF-1];
    int               frame_w;
    int               frame_h;
    int               shift_x;
    int               shift_y;
    logic [PIX_W-1:0] fill_pix;
    t_shift_pix       pending_pix [$];
    t_shift_pix       head;
    int               err_cnt = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [PIX_W-1:0] image_at(input int x, input int y);
        return image_mem[y * MAX_DIM_DEF + x];
    endfunction

    // bilinear blend of the translated reference at (px, py)
    function automatic t_shift_pix shifted_pixel(input int px, input int py);
        int         w;
        int         h;
        int         x0;
        int         y0;
        int         x1;
        int         y1;
        longint     sx;
        longint     sy;
        longint     fx;
        longint     fy;
        longint     row_a;
        longint     row_b;
        longint     blend;
        t_shift_pix res;
        w  = (frame_w > MAX_DIM_DEF) ? MAX_DIM_DEF : frame_w;
        h  = (frame_h > MAX_DIM_DEF) ? MAX_DIM_DEF : frame_h;
        sx = longint'(px) * FIX_ONE - longint'(shift_x);
        sy = longint'(py) * FIX_ONE - longint'(shift_y);
        if (w == 0 || h == 0 || sx < 0 || sy < 0 ||
            sx > longint'(w - 1) * FIX_ONE || sy > longint'(h - 1) * FIX_ONE) begin
            res.pix      = fill_pix;
            res.in_frame = 1'b0;
            return res;
        end
        x0 = int'(sx >>> FRAC_BITS_DEF);
        y0 = int'(sy >>> FRAC_BITS_DEF);
        fx = sx & (FIX_ONE - 1);
        fy = sy & (FIX_ONE - 1);
        // right and bottom neighbors stick to the last column and row
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        row_a = longint'(image_at(x0, y0)) * (FIX_ONE - fx) + longint'(image_at(x1, y0)) * fx;
        row_b = longint'(image_at(x0, y1)) * (FIX_ONE - fx) + longint'(image_at(x1, y1)) * fx;
        blend = row_a * (FIX_ONE - fy) + row_b * fy;
        blend = (blend + (FIX_ONE * FIX_ONE / 2)) >>> (2 * FRAC_BITS_DEF);
        res.pix      = (blend > longint'(PIX_MAX)) ? PIX_MAX : blend[PIX_W-1:0];
        res.in_frame = 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_w  = int'(DIM_RST);
            frame_h  = int'(DIM_RST);
            shift_x  = 0;
            shift_y  = 0;
            fill_pix = FILL_RST;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH:  frame_w  = int'(i_cfg_data[DIM_W-1:0]);
                    CFG_FRAME_HEIGHT: frame_h  = int'(i_cfg_data[DIM_W-1:0]);
                    CFG_SHIFT_X:      shift_x  = int'($signed(i_cfg_data[SHIFT_W-1:0]));
                    CFG_SHIFT_Y:      shift_y  = int'($signed(i_cfg_data[SHIFT_W-1:0]));
                    CFG_FILL_VALUE:   fill_pix = i_cfg_data[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (pending_pix.size() == 0) begin
                    $display("%0t: result with none expected: pixel_out %0d inside_res %0b",
                             $time, i_pixel_out, i_inside_res);
                    err_cnt++;
                end else begin
                    head = pending_pix.pop_front();
                    if (i_pixel_out !== head.pix) begin
                        $display("%0t: pixel_out expected %0d actual %0d",
                                 $time, head.pix, i_pixel_out);
                        err_cnt++;
                    end
                    if (i_inside_res !== head.in_frame) begin
                        $display("%0t: inside_res expected %0b actual %0b",
                                 $time, head.in_frame, i_inside_res);
                        err_cnt++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (t_mode'(i_mode) == MODE_WRITE) begin
                    image_mem[int'(i_pos_y) * MAX_DIM_DEF + int'(i_pos_x)] = i_pixel_in;
                end else begin
                    pending_pix.push_back(shifted_pixel(int'(i_pos_x), int'(i_pos_y)));
                end
            end
        end
        o_errors  <= err_cnt;
        o_pending <= pending_pix.size();
    end

endmodule

[tb/bilinear_subpixel_image_shift_unit_tb.sv]
// testbench top for the sub-pixel shift unit: clock, reset, item and register stimulus, verdict
`timescale 1ns / 100ps
module bilinear_subpixel_image_shift_unit_tb;
    import bsis_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASES        = 12;
    localparam int FIX_ONE       = 1 << FRAC_BITS_DEF;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic                  i_mode     = MODE_WRITE;
    logic [POS_W-1:0]      i_pos_x    = '0;
    logic [POS_W-1:0]      i_pos_y    = '0;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_done;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_inside_res;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors;
    int pending;
    int cycle_cnt  = 0;
    int items_sent = 0;
    int idle_pct   = 0;

    // register copies, kept to aim renders at written pixels
    int cfg_w  = int'(DIM_RST);
    int cfg_h  = int'(DIM_RST);
    int cfg_sx = 0;
    int cfg_sy = 0;
    bit written [0:MAX_DIM_DEF*MAX_DIM_DEF-1];
    int dim_pick [8] = '{0, 1, 2, 64, 511, 512, 513, 1023};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    bilinear_subpixel_image_shift_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_in   (i_pixel_in),
        .o_done       (o_done),
        .o_pixel_out  (o_pixel_out),
        .o_inside_res (o_inside_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    bilinear_subpixel_image_shift_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_mode       (i_mode),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pixel_in   (i_pixel_in),
        .i_done       (o_done),
        .i_pixel_out  (o_pixel_out),
        .i_inside_res (o_inside_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] rand_pix();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return PIX_MAX;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // neighbor cells of the source point; returns 0 when it falls outside the frame
    function automatic bit source_cell(input int px, input int py,
                                       output int x0, output int y0,
                                       output int x1, output int y1);
        int     w;
        int     h;
        longint sx;
        longint sy;
        w  = (cfg_w > MAX_DIM_DEF) ? MAX_DIM_DEF : cfg_w;
        h  = (cfg_h > MAX_DIM_DEF) ? MAX_DIM_DEF : cfg_h;
        sx = longint'(px) * FIX_ONE - longint'(cfg_sx);
        sy = longint'(py) * FIX_ONE - longint'(cfg_sy);
        if (w == 0 || h == 0 || sx < 0 || sy < 0 ||
            sx > longint'(w - 1) * FIX_ONE || sy > longint'(h - 1) * FIX_ONE) begin
            return 1'b0;
        end
        x0 = int'(sx >>> FRAC_BITS_DEF);
        y0 = int'(sy >>> FRAC_BITS_DEF);
        x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
        return 1'b1;
    endfunction

    task automatic push_item(input t_mode mode, input int x, input int y,
                             input logic [PIX_W-1:0] pix);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_mode     <= mode;
        i_pos_x    <= x[POS_W-1:0];
        i_pos_y    <= y[POS_W-1:0];
        i_pixel_in <= pix;
        do @(posedge i_clk); while (busy);
        if (mode == MODE_WRITE) written[y * MAX_DIM_DEF + x] = 1'b1;
        items_sent++;
    endtask

    // a render never reads an unwritten pixel: missing neighbors get written first
    task automatic render_at(input int x, input int y);
        int x0;
        int y0;
        int x1;
        int y1;
        if (source_cell(x, y, x0, y0, x1, y1)) begin
            if (!written[y0 * MAX_DIM_DEF + x0]) push_item(MODE_WRITE, x0, y0, rand_pix());
            if (!written[y0 * MAX_DIM_DEF + x1]) push_item(MODE_WRITE, x1, y0, rand_pix());
            if (!written[y1 * MAX_DIM_DEF + x0]) push_item(MODE_WRITE, x0, y1, rand_pix());
            if (!written[y1 * MAX_DIM_DEF + x1]) push_item(MODE_WRITE, x1, y1, rand_pix());
        end
        push_item(MODE_RENDER, x, y, PIX_W'($urandom_range(0, 255)));
    endtask

    // 2x2 patch of fresh pixels, then two to five renders aimed at it
    task automatic patch_and_probe();
        int ew;
        int eh;
        int bx;
        int by;
        int tx;
        int ty;
        ew = (cfg_w > MAX_DIM_DEF) ? MAX_DIM_DEF : cfg_w;
        eh = (cfg_h > MAX_DIM_DEF) ? MAX_DIM_DEF : cfg_h;
        bx = ($urandom_range(0, 3) == 0 && ew >= 2) ? ew - 2 : $urandom_range(0, MAX_DIM_DEF - 2);
        by = ($urandom_range(0, 3) == 0 && eh >= 2) ? eh - 2 : $urandom_range(0, MAX_DIM_DEF - 2);
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 2; i++) begin
                push_item(MODE_WRITE, bx + i, by + j, rand_pix());
            end
        end
        repeat ($urandom_range(2, 5)) begin
            tx = (((bx << FRAC_BITS_DEF) + cfg_sx) >>> FRAC_BITS_DEF) + int'($urandom_range(0, 1));
            ty = (((by << FRAC_BITS_DEF) + cfg_sy) >>> FRAC_BITS_DEF) + int'($urandom_range(0, 1));
            if (tx < 0 || tx >= MAX_DIM_DEF) tx = $urandom_range(0, MAX_DIM_DEF - 1);
            if (ty < 0 || ty >= MAX_DIM_DEF) ty = $urandom_range(0, MAX_DIM_DEF - 1);
            render_at(tx, ty);
        end
    endtask

    // hold off until every render is back, then let trailing writes leave the pipeline
    task automatic drain_and_settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the unit idle and start low
    task automatic set_config(input int w, input int h, input int sx, input int sy,
                              input int fill);
        logic [CFG_DATA_W-1:0] vals [5];
        t_cfg_idx              regs [5];
        regs = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_SHIFT_X, CFG_SHIFT_Y, CFG_FILL_VALUE};
        vals[0] = w[CFG_DATA_W-1:0];
        vals[1] = h[CFG_DATA_W-1:0];
        vals[2] = sx[CFG_DATA_W-1:0];
        vals[3] = sy[CFG_DATA_W-1:0];
        vals[4] = fill[CFG_DATA_W-1:0];
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_w  = int'(vals[0][DIM_W-1:0]);
        cfg_h  = int'(vals[1][DIM_W-1:0]);
        cfg_sx = int'($signed(vals[2][SHIFT_W-1:0]));
        cfg_sy = int'($signed(vals[3][SHIFT_W-1:0]));
    endtask

    initial begin
        int roll;
        int phase_end;
        int w;
        int h;
        int sx;
        int sy;
        int fill;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, origin and far corner patterns
        idle_pct = 25;
        push_item(MODE_WRITE, 0, 0, 8'h00);
        push_item(MODE_WRITE, 1, 0, 8'hFF);
        push_item(MODE_WRITE, 0, 1, 8'hFF);
        push_item(MODE_WRITE, 1, 1, 8'h00);
        push_item(MODE_WRITE, 511, 511, 8'hFF);
        render_at(0, 0);
        render_at(511, 511);
        render_at(511, 0);

        // half-pixel shift on a checkerboard gives an exact tie in rounding
        drain_and_settle();
        set_config(512, 512, 128, -128, 0);
        render_at(1, 0);
        render_at(0, 0);

        // oversized width, zero height
        drain_and_settle();
        set_config(1023, 0, 0, 0, 255);
        render_at(5, 5);

        // single-pixel frame, request beyond the frame shifted back onto it
        drain_and_settle();
        set_config(1, 1, 5 * FIX_ONE, 0, 17);
        render_at(5, 0);
        render_at(0, 0);

        // most negative and most positive shifts
        drain_and_settle();
        set_config(512, 512, -262144, 262143, 225);
        render_at(511, 0);
        render_at(0, 511);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_and_settle();
            idle_pct = (ph < 4) ? 25 : (ph < 8) ? 61 : 0;
            case (ph % 3)
                0: begin
                    w  = $urandom_range(64, 512);
                    h  = $urandom_range(64, 512);
                    sx = $urandom_range(0, 8191) - 4096;
                    sy = $urandom_range(0, 8191) - 4096;
                    if ($urandom_range(0, 2) == 0) sx = sx & ~255;
                    if ($urandom_range(0, 2) == 0) sy = sy & ~255;
                end
                1: begin
                    w = dim_pick[$urandom_range(0, 7)];
                    h = dim_pick[$urandom_range(0, 7)];
                    if ($urandom_range(0, 1) == 0) begin
                        sx = $urandom_range(0, 19'h7FFFF);
                        sy = $urandom_range(0, 19'h7FFFF);
                    end else begin
                        sx = $urandom_range(0, 511) - 256;
                        sy = $urandom_range(0, 511) - 256;
                    end
                end
                default: begin
                    w  = $urandom_range(0, 1023);
                    h  = $urandom_range(0, 1023);
                    sx = $urandom_range(0, 1023) - 512;
                    sy = $urandom_range(0, 1023) - 512;
                end
            endcase
            case ($urandom_range(0, 3))
                0:       fill = 0;
                1:       fill = 255;
                default: fill = $urandom_range(0, 255);
            endcase
            set_config(w, h, sx, sy, fill);
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    patch_and_probe();
                end else if (roll < 85) begin
                    render_at($urandom_range(0, MAX_DIM_DEF - 1), $urandom_range(0, MAX_DIM_DEF - 1));
                end else begin
                    push_item(MODE_WRITE, $urandom_range(0, MAX_DIM_DEF - 1),
                              $urandom_range(0, MAX_DIM_DEF - 1), rand_pix());
                end
                if ($urandom_range(0, 49) == 0) drain_and_settle();
            end
        end

        drain_and_settle();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
